>>> hw/rtl/gnee_pkg.sv
// Shared types and constants of the grid neighbor edge expander.
// Holds storage sizes, field widths, register indexes and the sequencer states.
// Depends on nothing.
package gnee_pkg;

  // grid storage
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = $clog2(MAX_ROWS * MAX_COLS);
  localparam int CODE_W   = 8;

  // field widths
  localparam int DIM_W      = 7;
  localparam int WEIGHT_W   = 16;
  localparam int NODE_W     = 12;
  localparam int NODE_PROD_W = ROW_W + DIM_W;
  localparam int CRD_W      = ROW_W + 2;

  // stream words
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // 3x3 window, positions 0..8 row-major, centre in the middle
  localparam int NUM_POS    = 9;
  localparam int POS_W      = 4;
  localparam int CENTER_POS = 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH      = 3'd0,
    CFG_GRID_HEIGHT     = 3'd1,
    CFG_OBSTACLE_CODE   = 3'd2,
    CFG_CARDINAL_WEIGHT = 3'd3,
    CFG_DIAGONAL_WEIGHT = 3'd4
  } cfg_idx_t;

  localparam logic [DIM_W-1:0]    RST_GRID_WIDTH  = 7'd64;
  localparam logic [DIM_W-1:0]    RST_GRID_HEIGHT = 7'd64;
  localparam logic [CODE_W-1:0]   RST_OBSTACLE    = 8'd35;
  localparam logic [WEIGHT_W-1:0] RST_CARDINAL    = 16'd256;
  localparam logic [WEIGHT_W-1:0] RST_DIAGONAL    = 16'd362;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_EXPAND = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

endpackage

>>> hw/rtl/gnee_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the cell grid of the edge expander. Depends on nothing.
module gnee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/grid_neighbor_edge_expander.sv
// Top level of the eight-connected grid neighbor edge expander.
// Holds the configuration registers, the window sequencer and the output register.
// Depends on gnee_pkg and gnee_ram.

// A write word (tuser 0) stores one cell code into the 64x64 grid RAM. An
// expand word (tuser 1) reads the 3x3 window around the named cell
// through the single read port of that RAM, one cell per cycle; it then
// emits one result word per cycle while the consumer does not stall, for
// each walkable neighbor in row-then-column order, with tlast on the
// final one, or a single word with tuser 0 when the cell is blocked, out
// of bounds or isolated. An expand yields n result words, n from 1 to 8.
// A new input word is taken only between expands; the final result word
// sits in the output register and does not hold off the next input.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata; the user
// must write it only while idle, as the block does not enforce this.
// Cells must be written before they are expanded; the grid has no reset.
module grid_neighbor_edge_expander (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [gnee_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [gnee_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // fields: cell_row [5:0], cell_col [11:6], cell_code [19:12], zero pad [23:20]
  input  logic [gnee_pkg::IN_TDATA_W-1:0]   in_tdata,
  // fields: op [0]
  input  logic [0:0]                        in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // fields: source_node [11:0], target_node [23:12], edge_weight [39:24]
  output logic [gnee_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // fields: edge_valid [0]
  output logic [0:0]                        out_tuser,
  output logic                              out_tlast
);

  import gnee_pkg::*;

  localparam logic [POS_W-1:0] LAST_STEP = POS_W'(NUM_POS);

  // window offsets per position: -1, 0, +1 in CRD_W two's complement
  function automatic logic [CRD_W-1:0] row_off(input logic [POS_W-1:0] k);
    logic [CRD_W-1:0] o;
    o = '0;
    if (k < POS_W'(3)) begin
      o = '1;
    end else if (k >= POS_W'(6)) begin
      o = CRD_W'(1);
    end
    return o;
  endfunction

  function automatic logic [CRD_W-1:0] col_off(input logic [POS_W-1:0] k);
    logic [CRD_W-1:0] o;
    o = '0;
    unique case (k)
      4'd0, 4'd3, 4'd6: o = '1;
      4'd2, 4'd5, 4'd8: o = CRD_W'(1);
      default:          o = '0;
    endcase
    return o;
  endfunction

  function automatic logic is_diag(input logic [POS_W-1:0] k);
    return (k == 4'd0) || (k == 4'd2) || (k == 4'd6) || (k == 4'd8);
  endfunction

  // configuration registers
  logic [DIM_W-1:0]    grid_width_r, grid_height_r;
  logic [CODE_W-1:0]   obstacle_r;
  logic [WEIGHT_W-1:0] cardinal_r, diagonal_r;

  // sequencer and datapath registers
  state_t              state_r, state_nxt;
  logic [POS_W-1:0]    rd_k_r, rd_k_nxt;
  logic                inb_d_r, inb_d_nxt;
  logic [NUM_POS-1:0]  walk_r, walk_nxt;
  logic [NUM_POS-1:0]  pend_r, pend_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;

  // output register
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                   out_tuser_r, out_tuser_nxt;
  logic                   out_tlast_r, out_tlast_nxt;

  // input word fields
  logic              in_acc;
  op_t               in_op;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [CODE_W-1:0] in_code;

  // window datapath
  logic [DIM_W-1:0]       eff_w, eff_h;
  logic [POS_W-1:0]       sel_j, pos;
  logic [NUM_POS-1:0]     rest;
  logic [CRD_W-1:0]       nb_row, nb_col;
  logic                   nb_inb;
  logic [NODE_PROD_W-1:0] src_prod, tgt_prod;
  logic                   cap_walk;
  logic [POS_W-1:0]       cap_k;
  logic                   out_free, load_out;

  // grid RAM ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CODE_W-1:0] ram_rdata;

  assign in_op   = op_t'(in_tuser[0]);
  assign in_row  = in_tdata[ROW_W-1:0];
  assign in_col  = in_tdata[ROW_W +: COL_W];
  assign in_code = in_tdata[ROW_W+COL_W +: CODE_W];
  assign in_acc  = in_tvalid && in_tready;

  // clamp the configured size to the storage
  assign eff_w = (grid_width_r > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_width_r;
  assign eff_h = (grid_height_r > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_height_r;

  // lowest pending neighbor
  always_comb begin
    logic found;
    found = 1'b0;
    sel_j = '0;
    for (int i = 0; i < NUM_POS; i++) begin
      if (!found && pend_r[i]) begin
        sel_j = POS_W'(i);
        found = 1'b1;
      end
    end
    rest = pend_r & ~(NUM_POS'(1) << sel_j);
  end

  // one coordinate path, shared by the window read and the edge emit
  assign pos    = (state_r == ST_READ) ? rd_k_r : sel_j;
  assign nb_row = CRD_W'(row_r) + row_off(pos);
  assign nb_col = CRD_W'(col_r) + col_off(pos);
  // a step off the low edge wraps to a large value and fails the compare
  assign nb_inb = (nb_row < CRD_W'(eff_h)) && (nb_col < CRD_W'(eff_w));

  assign src_prod = NODE_PROD_W'(row_r) * NODE_PROD_W'(eff_w) + NODE_PROD_W'(col_r);
  assign tgt_prod = NODE_PROD_W'(nb_row[ROW_W-1:0]) * NODE_PROD_W'(eff_w)
                  + NODE_PROD_W'(nb_col[COL_W-1:0]);

  // RAM: writes happen only while idle and read data is used only during a window scan,
  // so a write never meets a read whose data is used in one cycle
  assign ram_waddr = ADDR_W'(in_row) * ADDR_W'(MAX_COLS) + ADDR_W'(in_col);
  assign ram_raddr = ADDR_W'(nb_row[ROW_W-1:0]) * ADDR_W'(MAX_COLS)
                   + ADDR_W'(nb_col[COL_W-1:0]);

  assign cap_k    = rd_k_r - POS_W'(1);
  assign cap_walk = inb_d_r && (ram_rdata != obstacle_r);

  gnee_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAX_ROWS * MAX_COLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_code),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_op == OP_EXPAND) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_k_r == LAST_STEP) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && rest == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        // drop writes that fall outside the storage
        ram_we    = in_tvalid && in_op == OP_WRITE
                    && ({1'b0, in_row} < (ROW_W + 1)'(MAX_ROWS))
                    && ({1'b0, in_col} < (COL_W + 1)'(MAX_COLS));
      end
      ST_READ: begin
      end
      ST_EMIT: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    rd_k_nxt  = rd_k_r;
    inb_d_nxt = inb_d_r;
    walk_nxt  = walk_r;
    pend_nxt  = pend_r;

    if (state_r == ST_IDLE) begin
      row_nxt  = in_row;
      col_nxt  = in_col;
      rd_k_nxt = '0;
    end

    if (state_r == ST_READ) begin
      // advance the scan; remember whether the issued cell is in bounds
      rd_k_nxt  = rd_k_r + POS_W'(1);
      inb_d_nxt = nb_inb;
      if (rd_k_r != '0) begin
        for (int i = 0; i < NUM_POS; i++) begin
          if (cap_k == POS_W'(i)) begin
            walk_nxt[i] = cap_walk;
          end
        end
      end
      if (rd_k_r == LAST_STEP) begin
        pend_nxt = walk_nxt[CENTER_POS]
                   ? (walk_nxt & ~(NUM_POS'(1) << CENTER_POS)) : '0;
      end
    end

    if (load_out) begin
      pend_nxt = rest;
    end
  end

  // output register: hold until taken, reload when free
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;
    if (load_out) begin
      out_tvalid_nxt = 1'b1;
      if (pend_r == '0) begin
        // blocked, out of bounds or isolated cell
        out_tdata_nxt = '0;
        out_tuser_nxt = 1'b0;
        out_tlast_nxt = 1'b1;
      end else begin
        out_tdata_nxt = {is_diag(sel_j) ? diagonal_r : cardinal_r,
                         tgt_prod[NODE_W-1:0], src_prod[NODE_W-1:0]};
        out_tuser_nxt = 1'b1;
        out_tlast_nxt = (rest == '0);
      end
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;
  assign out_tlast    = out_tlast_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= RST_GRID_WIDTH;
      grid_height_r <= RST_GRID_HEIGHT;
      obstacle_r    <= RST_OBSTACLE;
      cardinal_r    <= RST_CARDINAL;
      diagonal_r    <= RST_DIAGONAL;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_GRID_WIDTH:      grid_width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_GRID_HEIGHT:     grid_height_r <= cfg_wdata[DIM_W-1:0];
        CFG_OBSTACLE_CODE:   obstacle_r    <= cfg_wdata[CODE_W-1:0];
        CFG_CARDINAL_WEIGHT: cardinal_r    <= cfg_wdata[WEIGHT_W-1:0];
        CFG_DIAGONAL_WEIGHT: diagonal_r    <= cfg_wdata[WEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    rd_k_r      <= rd_k_nxt;
    inb_d_r     <= inb_d_nxt;
    walk_r      <= walk_nxt;
    pend_r      <= pend_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

endmodule

>>> test/grid_neighbor_edge_expander_tb.sv
// Self-checking testbench for the grid neighbor edge expander.
// Drives write and expand words, predicts each edge run and checks every result word.
// Depends on gnee_pkg and grid_neighbor_edge_expander.
module grid_neighbor_edge_expander_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gnee_pkg::*;

  // percent of cycles in which either side idles
  localparam int IDLE_PCT     = 27;
  // cycles with no handshake at all before the run is declared hung
  localparam int STALL_LIMIT  = 1000;
  // settle time after the last result
  localparam int DRAIN_CYCLES = 24;

  // one input word as the generator builds it
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CODE_W-1:0] code;
    op_t               op;
  } grid_req_t;

  // one expected result word
  typedef struct {
    logic [NODE_W-1:0]   src;
    logic [NODE_W-1:0]   dst;
    logic [WEIGHT_W-1:0] weight;
    logic                valid;
    logic                tail;
  } edge_rec_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [0:0]             in_tuser  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   out_tlast;

  grid_neighbor_edge_expander u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // words waiting for the driver, and expected edge words waiting for the block
  grid_req_t pending_words [$];
  edge_rec_t edge_expect [$];
  grid_req_t next_word;

  int queued_count   = 0;
  int accepted_count = 0;
  int error_count    = 0;
  int quiet_cycles   = 0;
  logic in_taken     = 1'b0;
  logic no_idle      = 1'b0;

  // predictor copy of the grid and the registers, tracked from the ports
  logic [CODE_W-1:0]   grid_model [0:MAX_ROWS*MAX_COLS-1];
  logic [DIM_W-1:0]    m_width    = RST_GRID_WIDTH;
  logic [DIM_W-1:0]    m_grid_h   = RST_GRID_HEIGHT;
  logic [CODE_W-1:0]   m_obstacle = RST_OBSTACLE;
  logic [WEIGHT_W-1:0] m_cardinal = RST_CARDINAL;
  logic [WEIGHT_W-1:0] m_diagonal = RST_DIAGONAL;

  // generator view: effective grid of the current phase and which cells hold a code
  int gen_w   = MAX_COLS;
  int gen_h   = MAX_ROWS;
  int gen_obs = RST_OBSTACLE;
  bit written [0:MAX_ROWS*MAX_COLS-1];

  // ---------------------------------------------------------------------------
  // Edge predictor
  // ---------------------------------------------------------------------------

  function automatic bit walkable_at(input int r, input int c, input int w, input int h);
    if (r < 0 || r >= h || c < 0 || c >= w)
      walkable_at = 1'b0;
    else
      walkable_at = grid_model[r*MAX_COLS + c] != m_obstacle;
  endfunction

  function automatic logic [NODE_W-1:0] node_of(input int r, input int c, input int w);
    node_of = NODE_W'(r * w + c);
  endfunction

  // Apply one accepted word: store a code, or queue the edge run of an expand.
  task automatic predict_word(input op_t op, input int r, input int c,
                              input logic [CODE_W-1:0] code);
    edge_rec_t run [8];
    int w, h, n;
    w = (m_width > MAX_COLS) ? MAX_COLS : int'(m_width);
    h = (m_grid_h > MAX_ROWS) ? MAX_ROWS : int'(m_grid_h);
    n = 0;
    if (op == OP_WRITE) begin
      grid_model[r*MAX_COLS + c] = code;
    end else begin
      if (walkable_at(r, c, w, h)) begin
        // visit row offsets -1..1 and, within each, column offsets -1..1, skip the centre
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (!(dr == 0 && dc == 0) && walkable_at(r + dr, c + dc, w, h)) begin
              run[n].src    = node_of(r, c, w);
              run[n].dst    = node_of(r + dr, c + dc, w);
              run[n].weight = (dr != 0 && dc != 0) ? m_diagonal : m_cardinal;
              run[n].valid  = 1'b1;
              run[n].tail   = 1'b0;
              n++;
            end
          end
        end
      end
      if (n == 0) begin
        // blocked, out of bounds or isolated: one all-zero word marked invalid
        run[0].src    = '0;
        run[0].dst    = '0;
        run[0].weight = '0;
        run[0].valid  = 1'b0;
        run[0].tail   = 1'b1;
        n = 1;
      end else begin
        run[n-1].tail = 1'b1;
      end
      for (int i = 0; i < n; i++)
        edge_expect.insert(edge_expect.size(), run[i]);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [WEIGHT_W-1:0] want_v,
                                 input logic [WEIGHT_W-1:0] got_v);
    error_count++;
    $display("%0t ns: %s expected %0d, actual %0d", $time, what, want_v, got_v);
  endtask

  // Compare one result word, field by field, against the oldest expectation.
  task automatic check_result();
    edge_rec_t want;
    if (edge_expect.size() == 0) begin
      error_count++;
      $display("%0t ns: result word expected none, actual source %0d target %0d",
               $time, out_tdata[11:0], out_tdata[23:12]);
    end else begin
      want = edge_expect.pop_front();
      if (out_tdata[11:0] !== want.src)
        report_mismatch("source_node", WEIGHT_W'(want.src), WEIGHT_W'(out_tdata[11:0]));
      if (out_tdata[23:12] !== want.dst)
        report_mismatch("target_node", WEIGHT_W'(want.dst), WEIGHT_W'(out_tdata[23:12]));
      if (out_tdata[39:24] !== want.weight)
        report_mismatch("edge_weight", want.weight, out_tdata[39:24]);
      if (out_tuser[0] !== want.valid)
        report_mismatch("edge_valid", WEIGHT_W'(want.valid), WEIGHT_W'(out_tuser[0]));
      if (out_tlast !== want.tail)
        report_mismatch("last", WEIGHT_W'(want.tail), WEIGHT_W'(out_tlast));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels and the config port at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_GRID_WIDTH:      m_width    = cfg_wdata[DIM_W-1:0];
          CFG_GRID_HEIGHT:     m_grid_h   = cfg_wdata[DIM_W-1:0];
          CFG_OBSTACLE_CODE:   m_obstacle = cfg_wdata[CODE_W-1:0];
          CFG_CARDINAL_WEIGHT: m_cardinal = cfg_wdata[WEIGHT_W-1:0];
          CFG_DIAGONAL_WEIGHT: m_diagonal = cfg_wdata[WEIGHT_W-1:0];
          default: ;
        endcase
      end
      // check outputs before predicting: a word taken now cannot answer yet
      if (out_tvalid && out_tready)
        check_result();
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        predict_word(op_t'(in_tuser[0]), int'(in_tdata[5:0]), int'(in_tdata[11:6]),
                     in_tdata[19:12]);
        accepted_count++;
      end
      // watchdog: any handshake or register write counts as progress
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: feed the input channel from the pending queue at the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // hold the word until the block takes it
    end else if (pending_words.size() != 0 &&
                 (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
      next_word = pending_words.pop_front();
      in_tvalid <= 1'b1;
      in_tdata  <= {4'b0, next_word.code, next_word.col, next_word.row};
      in_tuser  <= next_word.op;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // stall the result channel at random, never during the steady stretch
  always @(negedge clk)
    out_tready <= rst_n && (no_idle || $urandom_range(99) >= IDLE_PCT);

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  // Pick a coordinate: mostly inside the grid, biased to its borders when large,
  // sometimes just past the edge or anywhere in storage.
  function automatic int pick_coord(input int limit);
    int roll;
    roll = $urandom_range(99);
    if (limit == 0 || roll < 10)
      pick_coord = $urandom_range(MAX_ROWS - 1);
    else if (roll < 15 && limit < MAX_ROWS)
      pick_coord = limit;
    else if (limit > 8 && roll < 40)
      pick_coord = $urandom_range(3);
    else if (limit > 8 && roll < 70)
      pick_coord = limit - 1 - $urandom_range(3);
    else
      pick_coord = $urandom_range(limit - 1);
  endfunction

  // roughly a third of the codes block the cell
  function automatic logic [CODE_W-1:0] pick_code();
    if ($urandom_range(99) < 30)
      pick_code = CODE_W'(gen_obs);
    else
      pick_code = CODE_W'($urandom_range(255));
  endfunction

  task automatic queue_write(input int r, input int c, input logic [CODE_W-1:0] v);
    grid_req_t q;
    q.op   = OP_WRITE;
    q.row  = ROW_W'(r);
    q.col  = COL_W'(c);
    q.code = v;
    pending_words.insert(pending_words.size(), q);
    queued_count++;
    written[r*MAX_COLS + c] = 1'b1;
  endtask

  // Queue an expand; first give every in-bounds cell of its window a code so
  // that the block never reads a cell that was never written.
  task automatic queue_expand(input int r, input int c);
    grid_req_t q;
    int rr, cc;
    if (r < gen_h && c < gen_w) begin
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          rr = r + dr;
          cc = c + dc;
          if (rr >= 0 && rr < gen_h && cc >= 0 && cc < gen_w && !written[rr*MAX_COLS + cc])
            queue_write(rr, cc, pick_code());
        end
      end
    end
    q.op   = OP_EXPAND;
    q.row  = ROW_W'(r);
    q.col  = COL_W'(c);
    q.code = CODE_W'($urandom_range(255));
    pending_words.insert(pending_words.size(), q);
    queued_count++;
  endtask

  // Pause the sender until every word is taken and every result is back,
  // then let the block settle.
  task automatic wait_for_idle();
    while (accepted_count != queued_count || edge_expect.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write all five registers back to back; call only while the block is idle.
  task automatic set_registers(input int w, input int h, input int obs,
                               input int card, input int diag);
    cfg_idx_t regs [5];
    int       vals [5];
    regs[0] = CFG_GRID_WIDTH;      vals[0] = w;
    regs[1] = CFG_GRID_HEIGHT;     vals[1] = h;
    regs[2] = CFG_OBSTACLE_CODE;   vals[2] = obs;
    regs[3] = CFG_CARDINAL_WEIGHT; vals[3] = card;
    regs[4] = CFG_DIAGONAL_WEIGHT; vals[4] = diag;
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= regs[i];
      cfg_wdata <= CFG_DATA_W'(vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // One phase: new settings, then a random mix of writes and expands.
  task automatic run_phase(input int w, input int h, input int obs, input int card,
                           input int diag, input int iters);
    int r, c;
    set_registers(w, h, obs, card, diag);
    gen_w   = (w > MAX_COLS) ? MAX_COLS : w;
    gen_h   = (h > MAX_ROWS) ? MAX_ROWS : h;
    gen_obs = obs;
    for (int i = 0; i < iters; i++) begin
      r = pick_coord(gen_h);
      c = pick_coord(gen_w);
      if ($urandom_range(99) < 35)
        queue_write(r, c, pick_code());
      else
        queue_expand(r, c);
    end
    wait_for_idle();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset settings (64 x 64, obstacle 35).
    // Top-left corner: one blocked and two walkable neighbors.
    queue_write(0, 0, 8'h00);
    queue_write(0, 1, RST_OBSTACLE);
    queue_write(1, 0, 8'hFF);
    queue_write(1, 1, 8'h5A);
    queue_expand(0, 0);
    // Blocked centre: a single invalid word.
    queue_write(0, 2, 8'h80);
    queue_write(1, 2, RST_OBSTACLE);
    queue_expand(0, 1);
    // Interior cell with a mix of cardinal and diagonal edges.
    queue_write(2, 0, RST_OBSTACLE);
    queue_write(2, 1, 8'h01);
    queue_write(2, 2, 8'hFE);
    queue_expand(1, 1);
    // Bottom-right corner: highest node ids.
    queue_write(63, 63, 8'hA5);
    queue_write(62, 62, 8'h22);
    queue_write(62, 63, RST_OBSTACLE);
    queue_write(63, 62, 8'h24);
    queue_expand(63, 63);
    // Isolated cell: walkable but every neighbor blocked.
    queue_write(0, 63, 8'h7F);
    queue_write(0, 62, RST_OBSTACLE);
    queue_write(1, 62, RST_OBSTACLE);
    queue_write(1, 63, RST_OBSTACLE);
    queue_expand(0, 63);
    wait_for_idle();

    // Random phases; each starts from an idle block with fresh settings.
    run_phase(5, 4, RST_OBSTACLE, RST_CARDINAL, RST_DIAGONAL, 40);
    run_phase(1, 1, 0, 65535, 0, 20);
    // full grid with no idling on either side
    no_idle = 1'b1;
    run_phase(64, 64, 255, 0, 65535, 15);
    no_idle = 1'b0;
    // zero width: every cell out of bounds; oversized height is clamped
    run_phase(0, 127, RST_OBSTACLE, $urandom_range(65535), $urandom_range(65535), 20);
    run_phase(127, 3, 8'hA5, $urandom_range(65535), $urandom_range(65535), 20);
    run_phase(3, 64, $urandom_range(255), 1, 2, 20);
    run_phase(8, 7, $urandom_range(255), $urandom_range(65535), $urandom_range(65535), 30);

    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/gnee_pkg.sv
hw/rtl/gnee_ram.sv
hw/rtl/grid_neighbor_edge_expander.sv
test/grid_neighbor_edge_expander_tb.sv
